>>> hw/rtl/arxbhe_pkg.sv
// arxbhe_pkg: shared types, constants and sequencer states for the arx block hash engine
// no dependencies; imported by arxbhe_round and arx_block_hash_engine
package arxbhe_pkg;

  // sizes
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned BLOCK_WORDS   = 8;
  localparam int unsigned POS_W         = 3;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned SALT_CNT_W    = 4;
  localparam int unsigned ROUND_COUNT_D = 64;

  // fixed key words and the salted-key increment
  localparam logic [BLOCK_WORDS-1:0][WORD_W-1:0] BASE_KEY = {
    32'h8a348b7d, 32'hb5f3810a, 32'h45000057, 32'h31ba94b9,
    32'hb8a79b02, 32'h0059c491, 32'hacdef012, 32'h72000000
  };
  localparam logic [WORD_W-1:0] KEY_INC = 32'h00000001;

  // rotate amounts of the mixing round
  localparam int unsigned ROT_A = 2;
  localparam int unsigned ROT_B = 5;
  localparam int unsigned ROT_C = 7;
  localparam int unsigned ROT_D = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SALT_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SALT_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SALT_C    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SALT_D    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SALT_CNT  = 3'd4;

  // chain of eight words, word 0 in the low slot
  typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] chain_t;

  // channel words
  typedef struct packed {
    logic [WORD_W-1:0] message_word;
    logic              last_word;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] digest_word;
    logic [POS_W-1:0]  digest_index;
    logic              digest_last;
  } out_word_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SNAP,
    ST_MIX,
    ST_ADD,
    ST_OUT
  } seq_state_t;

endpackage

>>> hw/rtl/arxbhe_round.sv
// arxbhe_round: one add/xor-rotate mixing round followed by a one-word left rotation
// depends on arxbhe_pkg
module arxbhe_round (
  input  arxbhe_pkg::chain_t h_in,
  output arxbhe_pkg::chain_t h_out
);
  import arxbhe_pkg::*;

  chain_t h;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned n);
    rotl = (v << n) | (v >> (WORD_W - n));
  endfunction

  // mixing; word 7 takes the updated word 0
  always_comb begin
    h[0] = h_in[0] + h_in[1];
    h[1] = rotl(h_in[1] ^ h_in[2], ROT_A);
    h[2] = h_in[2] + h_in[3];
    h[3] = rotl(h_in[3] ^ h_in[4], ROT_B);
    h[4] = h_in[4] + h_in[5];
    h[5] = rotl(h_in[5] ^ h_in[6], ROT_C);
    h[6] = h_in[6] + h_in[7];
    h[7] = rotl(h_in[7] ^ h[0], ROT_D);
  end

  // word rotation: word 0 moves to the top
  always_comb begin
    for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
      h_out[i] = h[i+1];
    end
    h_out[BLOCK_WORDS-1] = h[0];
  end

endmodule

>>> hw/rtl/arx_block_hash_engine.sv
// arx_block_hash_engine: salted 256-bit add/xor-rotate hash engine, top level
// depends on arxbhe_pkg and arxbhe_round

// Message words enter one per cycle while in_stall is low; each is XORed with its
// (optionally salted) key word into the chain. Words that fill a block (the eighth)
// or that are marked last start block processing: remaining positions of a last
// block are filled with zero message words, the snapshot is taken (ST_SNAP),
// ROUND_COUNT rounds run through the shared round unit (ST_MIX), and the snapshot
// is added back (ST_ADD). The input is stalled from the eighth or last word until
// the block is done, and after a last word until its digest is out. After a last
// word the eight digest words leave on the out channel, first word first, one per
// cycle unless stalled; the chain then clears for the next message. Configuration
// writes are taken at any time but are meant for idle periods.
module arx_block_hash_engine #(
  parameter int unsigned ROUND_COUNT = arxbhe_pkg::ROUND_COUNT_D
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  arxbhe_pkg::in_word_t                   in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output arxbhe_pkg::out_word_t                  out_data,
  input  logic                                   cfg_wr_en,
  input  logic [arxbhe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [arxbhe_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import arxbhe_pkg::*;

  localparam int unsigned RND_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUND_COUNT - 1);

  seq_state_t state_r, state_nxt;
  chain_t chain_r, chain_nxt;
  chain_t snap_r;
  chain_t round_out;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic [POS_W-1:0] oidx_r, oidx_nxt;
  logic last_pend_r, last_pend_nxt;
  logic [BLOCK_WORDS-1:0][WORD_W-1:0] salt_r;
  logic [SALT_CNT_W-1:0] salt_cnt_r;
  logic [WORD_W-1:0] key_word;
  logic [WORD_W-1:0] absorb_word;
  logic [WORD_W-1:0] absorbed;
  logic in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // shared round unit
  arxbhe_round u_round (
    .h_in  (chain_r),
    .h_out (round_out)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      salt_r     <= '0;
      salt_cnt_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SALT_A: begin
          salt_r[0] <= cfg_wdata[63:32];
          salt_r[1] <= cfg_wdata[31:0];
        end
        CFG_SALT_B: begin
          salt_r[2] <= cfg_wdata[63:32];
          salt_r[3] <= cfg_wdata[31:0];
        end
        CFG_SALT_C: begin
          salt_r[4] <= cfg_wdata[63:32];
          salt_r[5] <= cfg_wdata[31:0];
        end
        CFG_SALT_D: begin
          salt_r[6] <= cfg_wdata[63:32];
          salt_r[7] <= cfg_wdata[31:0];
        end
        CFG_SALT_CNT: salt_cnt_r <= cfg_wdata[SALT_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // key word for the current position; counts of eight and above salt every word
  always_comb begin
    key_word = BASE_KEY[pos_r];
    if ({1'b0, pos_r} < salt_cnt_r) begin
      key_word = (BASE_KEY[pos_r] ^ salt_r[pos_r]) + KEY_INC;
    end
  end

  // absorb path: real word when idle, zero during fill
  assign absorb_word = (state_r == ST_IDLE) ? in_data.message_word : '0;
  assign absorbed    = chain_r[pos_r] ^ absorb_word ^ key_word;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    chain_nxt     = chain_r;
    pos_nxt       = pos_r;
    rnd_nxt       = rnd_r;
    oidx_nxt      = oidx_r;
    last_pend_nxt = last_pend_r;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          chain_nxt[pos_r] = absorbed;
          pos_nxt          = pos_r + 1'b1;
          last_pend_nxt    = in_data.last_word;
          if (pos_r == POS_W'(BLOCK_WORDS - 1)) begin
            state_nxt = ST_SNAP;
          end else if (in_data.last_word) begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        chain_nxt[pos_r] = absorbed;
        pos_nxt          = pos_r + 1'b1;
        if (pos_r == POS_W'(BLOCK_WORDS - 1)) begin
          state_nxt = ST_SNAP;
        end
      end
      ST_SNAP: begin
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        chain_nxt = round_out;
        rnd_nxt   = rnd_r + 1'b1;
        if (rnd_r == RND_LAST) begin
          rnd_nxt   = '0;
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < BLOCK_WORDS; i++) begin
          chain_nxt[i] = chain_r[i] + snap_r[i];
        end
        state_nxt = last_pend_r ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          // rotate so the next digest word sits in slot 0
          for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            chain_nxt[i] = chain_r[i+1];
          end
          chain_nxt[BLOCK_WORDS-1] = chain_r[0];
          oidx_nxt = oidx_r + 1'b1;
          if (oidx_r == POS_W'(BLOCK_WORDS - 1)) begin
            chain_nxt     = '0;
            last_pend_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // digest word comes straight from chain slot 0
  always_comb begin
    out_data.digest_word  = chain_r[0];
    out_data.digest_index = oidx_r;
    out_data.digest_last  = (oidx_r == POS_W'(BLOCK_WORDS - 1));
  end

  // control and chain registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chain_r     <= '0;
      pos_r       <= '0;
      rnd_r       <= '0;
      oidx_r      <= '0;
      last_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      pos_r       <= pos_nxt;
      rnd_r       <= rnd_nxt;
      oidx_r      <= oidx_nxt;
      last_pend_r <= last_pend_nxt;
    end
  end

  // snapshot of the chain before mixing
  always_ff @(posedge clk) begin
    if (state_r == ST_SNAP) begin
      snap_r <= chain_r;
    end
  end

  // round counter rests at zero outside the mixing phase
  a_rnd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_MIX) |-> (rnd_r == '0))
    else $error("round counter nonzero outside mixing");

  // a full block always hands over to the snapshot step
  a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && pos_r == POS_W'(BLOCK_WORDS - 1)) |=> (state_r == ST_SNAP))
    else $error("full block did not start mixing");

  // digest words only go out on a block boundary
  a_out_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pos_r == '0 && last_pend_r))
    else $error("digest output off a block boundary");

  // final digest word returns the block to idle with a cleared chain
  a_out_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_data.digest_last) |=> (state_r == ST_IDLE && chain_r == '0))
    else $error("chain not cleared after digest");

endmodule
